@@ sv/frame_bitmap_allocator_macros.svh @@
// Assertion macros shared by the frame bitmap allocator RTL.
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on clk and ignored while rst_n is low.
`define FBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and ignored while rst_n is low.
`define FBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fba_pkg.sv @@
// Shared constants and types for the frame bitmap allocator.
`default_nettype none

package fba_pkg;

  localparam int unsigned FRAME_W = 12;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned WIDX_W  = FRAME_W - BIT_W;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Result of the lowest-zero search over one bitmap word.
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } fz_res_t;

endpackage

`default_nettype wire

@@ sv/fba_bitmap.sv @@
// Used-frame bitmap memory: one write port, one read port with registered data.
`default_nettype none

module fba_bitmap
  import fba_pkg::*;
#(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/fba_first_zero.sv @@
// Search unit: lowest clear bit of one bitmap word.
`default_nettype none

module fba_first_zero
  import fba_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  output      fz_res_t           res
);

  always_comb begin
    res = '0;
    // Walk from the top so the lowest clear bit wins.
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.idx   = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/frame_bitmap_allocator.sv @@
// Top level: first-fit page-frame allocator over a used-frame bitmap.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | operation, current_frame, is_kernel,
//          |           |                  | is_writable, frame_number
//  out_    | output    | out_valid/stall  | new_frame, present, writable,
//          |           |                  | user_access, frame_in_use, status
//
// Allocate scans one bitmap word per cycle through the single memory read port,
// starting at word 0, until it finds a clear bit or passes the last word.
// Free and test read the word, then modify it or report; skipped and
// out-of-map items are accepted, then answered.
// After reset a clearing pass writes every word once, during which in_stall stays high.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is loaded into the output register, and a stalled output holds the
// sequencer in its final step.
`default_nettype none

module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [FRAME_W-1:0] in_current_frame,
  input  wire logic               in_is_kernel,
  input  wire logic               in_is_writable,
  input  wire logic [FRAME_W-1:0] in_frame_number,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [FRAME_W-1:0] out_new_frame,
  output      logic               out_present,
  output      logic               out_writable,
  output      logic               out_user_access,
  output      logic               out_frame_in_use,
  output      logic [1:0]         out_status
);

`include "frame_bitmap_allocator_macros.svh"

  localparam int unsigned NUM_WORDS = NUM_FRAMES / WORD_W;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               issue_r, issue_nxt;
  logic               chk_v_r, chk_v_nxt;
  logic [ADDR_W-1:0]  chk_addr_r, chk_addr_nxt;

  logic [1:0]         op_r, op_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic               kern_r, kern_nxt;
  logic               wr_r, wr_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_pres_r, out_pres_nxt;
  logic               out_rw_r, out_rw_nxt;
  logic               out_usr_r, out_usr_nxt;
  logic               out_inuse_r, out_inuse_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               mem_wr_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  logic [WORD_W-1:0]  mem_wr_data;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic [WORD_W-1:0]  mem_rd_data;

  fz_res_t            fz;

  logic               accept;
  logic               out_free;
  logic               fin;
  logic [WIDX_W-1:0]  cur_widx;
  logic [WIDX_W-1:0]  tf_widx;
  logic               cur_in_map;
  logic               tf_in_map;
  logic               cur_r_in_map;
  logic               scan_hit;
  logic               scan_end;
  logic               scan_pipe;

  fba_bitmap #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (ADDR_W)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  fba_first_zero u_first_zero (
    .word (mem_rd_data),
    .res  (fz)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign cur_widx     = in_current_frame[FRAME_W-1:BIT_W];
  assign tf_widx      = in_frame_number[FRAME_W-1:BIT_W];
  assign cur_in_map   = 32'(cur_widx) < NUM_WORDS;
  assign tf_in_map    = 32'(tf_widx) < NUM_WORDS;
  assign cur_r_in_map = 32'(cur_r[FRAME_W-1:BIT_W]) < NUM_WORDS;

  assign scan_hit  = chk_v_r && fz.found;
  assign scan_end  = chk_v_r && !fz.found && (chk_addr_r == LAST_ADDR);
  assign scan_pipe = (state_r == S_SCAN) && issue_r && chk_v_r;

  always_comb begin
    state_nxt    = state_r;
    rd_addr_nxt  = rd_addr_r;
    issue_nxt    = issue_r;
    chk_v_nxt    = chk_v_r;
    chk_addr_nxt = chk_addr_r;
    op_nxt       = op_r;
    cur_nxt      = cur_r;
    kern_nxt     = kern_r;
    wr_nxt       = wr_r;
    bit_nxt      = bit_r;

    mem_wr_en   = 1'b0;
    mem_wr_addr = rd_addr_r;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_addr_r;

    fin            = 1'b0;
    out_frame_nxt  = cur_r;
    out_pres_nxt   = 1'b0;
    out_rw_nxt     = 1'b0;
    out_usr_nxt    = 1'b0;
    out_inuse_nxt  = 1'b0;
    out_status_nxt = ST_DONE;

    case (state_r)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
        if (rd_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr_nxt = rd_addr_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_operation;
          cur_nxt   = in_current_frame;
          kern_nxt  = in_is_kernel;
          wr_nxt    = in_is_writable;
          state_nxt = S_RESP;
          case (in_operation)
            OP_ALLOC: begin
              if (in_current_frame == '0) begin
                state_nxt   = S_SCAN;
                rd_addr_nxt = '0;
                issue_nxt   = 1'b1;
                chk_v_nxt   = 1'b0;
              end
            end
            OP_FREE: begin
              if ((in_current_frame != '0) && cur_in_map) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(cur_widx);
                bit_nxt     = in_current_frame[BIT_W-1:0];
                state_nxt   = S_RMW;
              end
            end
            OP_TEST: begin
              if (tf_in_map) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(tf_widx);
                bit_nxt     = in_frame_number[BIT_W-1:0];
                state_nxt   = S_TEST;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_hit || scan_end) begin
          // Hold the checked word until the output register frees up.
          if (out_free) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
            if (scan_hit) begin
              mem_wr_en     = 1'b1;
              mem_wr_addr   = chk_addr_r;
              mem_wr_data   = mem_rd_data | (WORD_W'(1) << fz.idx);
              out_frame_nxt = FRAME_W'({chk_addr_r, fz.idx});
              out_pres_nxt  = 1'b1;
              out_rw_nxt    = wr_r;
              out_usr_nxt   = !kern_r;
            end else begin
              out_frame_nxt  = '0;
              out_status_nxt = ST_FULL;
            end
          end
        end else begin
          mem_rd_en    = issue_r;
          chk_v_nxt    = issue_r;
          chk_addr_nxt = rd_addr_r;
          if (issue_r) begin
            if (rd_addr_r == LAST_ADDR) begin
              issue_nxt = 1'b0;
            end else begin
              rd_addr_nxt = rd_addr_r + ADDR_W'(1);
            end
          end
        end
      end

      S_RMW: begin
        if (out_free) begin
          fin           = 1'b1;
          state_nxt     = S_IDLE;
          mem_wr_en     = 1'b1;
          mem_wr_addr   = ADDR_W'(cur_r[FRAME_W-1:BIT_W]);
          mem_wr_data   = mem_rd_data & ~(WORD_W'(1) << bit_r);
          out_frame_nxt = '0;
        end
      end

      S_TEST: begin
        if (out_free) begin
          fin           = 1'b1;
          state_nxt     = S_IDLE;
          out_inuse_nxt = mem_rd_data[bit_r];
        end
      end

      S_RESP: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_ALLOC: begin
              out_status_nxt = ST_SKIP;
            end
            OP_FREE: begin
              // Empty entry is skipped; a frame past the bitmap just drops.
              out_frame_nxt = '0;
              if (cur_r == '0) begin
                out_status_nxt = ST_SKIP;
              end
            end
            OP_TEST: begin
              out_status_nxt = ST_DONE;
            end
            default: begin
              out_status_nxt = ST_SKIP;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      rd_addr_r   <= '0;
      issue_r     <= 1'b0;
      chk_v_r     <= 1'b0;
      chk_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_addr_r   <= rd_addr_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      chk_addr_r  <= chk_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    cur_r  <= cur_nxt;
    kern_r <= kern_nxt;
    wr_r   <= wr_nxt;
    bit_r  <= bit_nxt;
    if (fin) begin
      out_frame_r  <= out_frame_nxt;
      out_pres_r   <= out_pres_nxt;
      out_rw_r     <= out_rw_nxt;
      out_usr_r    <= out_usr_nxt;
      out_inuse_r  <= out_inuse_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_frame    = out_frame_r;
  assign out_present      = out_pres_r;
  assign out_writable     = out_rw_r;
  assign out_user_access  = out_usr_r;
  assign out_frame_in_use = out_inuse_r;
  assign out_status       = out_status_r;

  `FBA_ASSERT_NXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "idle after accept")

  `FBA_ASSERT_IMP(a_out_rise_src, $rose(out_valid_r), $past(state_r) > S_IDLE, "stray result")

  `FBA_ASSERT_IMP(a_scan_lag, scan_pipe, rd_addr_r == chk_addr_r + ADDR_W'(1), "scan lag")

  `FBA_ASSERT_IMP(a_present_done, out_valid_r && out_present, out_status == ST_DONE, "bad status")

  `FBA_ASSERT_IMP(a_free_in_map, state_r == S_RMW, (cur_r != '0) && cur_r_in_map, "bad free")

endmodule

`default_nettype wire
